### hw/rtl/word_stack_push_pop_peek_swap_top_macros.svh
// ----------------------------------------------------------------------------
// Word stack assertion macros
// Concurrent assertion wrappers, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef WORD_STACK_PUSH_POP_PEEK_SWAP_TOP_MACROS_SVH
`define WORD_STACK_PUSH_POP_PEEK_SWAP_TOP_MACROS_SVH

`ifndef ASSERT_OFF
`define WSTK_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define WSTK_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);
`else
`define WSTK_ASSERT(lbl, prop, msg)
`define WSTK_ASSERT_NEVER(lbl, cond, msg)
`endif

`endif

### hw/rtl/wstk_pkg.sv
// ----------------------------------------------------------------------------
// Word stack package
// Shared widths, action and status codes, and the front-to-back control word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package wstk_pkg;

	localparam int WSTK_STACK_DEPTH = 1024;
	localparam int WSTK_SWAP_REACH  = 15;
	localparam int WSTK_QUEUE_DEPTH = 2;

	localparam int PART_W = 64;
	localparam int PARTS  = 4;
	localparam int WORD_W = PART_W * PARTS;
	localparam int POS_W  = 10;
	localparam int FILL_W = 11;

	typedef enum logic [1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_PEEK = 2'd2,
		OP_SWAP = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_OK       = 2'd0,
		ST_OVERFLOW = 2'd1,
		ST_UNDERFLOW = 2'd2,
		ST_NOACCESS = 2'd3
	} status_t;

	typedef struct packed {
		op_t                op;
		status_t            status;
		logic [FILL_W-1:0]  fill;
	} ctrl_t;

endpackage

### hw/rtl/wstk_req_if.sv
// ----------------------------------------------------------------------------
// Word stack request channel
// Valid/ready channel carrying one stack action per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wstk_req_if
	import wstk_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        action;
	logic [POS_W-1:0]  position;
	logic [PART_W-1:0] value_word0;
	logic [PART_W-1:0] value_word1;
	logic [PART_W-1:0] value_word2;
	logic [PART_W-1:0] value_word3;

	modport source (
		output valid, action, position, value_word0, value_word1, value_word2, value_word3,
		input  ready
	);

	modport sink (
		input  valid, action, position, value_word0, value_word1, value_word2, value_word3,
		output ready
	);
endinterface

### hw/rtl/wstk_rsp_if.sv
// ----------------------------------------------------------------------------
// Word stack response channel
// Valid/ready channel carrying one result per transaction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface wstk_rsp_if
	import wstk_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [PART_W-1:0] read_word0;
	logic [PART_W-1:0] read_word1;
	logic [PART_W-1:0] read_word2;
	logic [PART_W-1:0] read_word3;
	logic [1:0]        status;
	logic [FILL_W-1:0] fill;

	modport source (
		output valid, read_word0, read_word1, read_word2, read_word3, status, fill,
		input  ready
	);

	modport sink (
		input  valid, read_word0, read_word1, read_word2, read_word3, status, fill,
		output ready
	);
endinterface

### hw/rtl/wstk_queue.sv
// ----------------------------------------------------------------------------
// Word stack command queue
// Short FIFO of classified commands between the front and the back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstk_queue
	import wstk_pkg::*;
#(
	parameter int ADDR_W = 10
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ctrl_t             push_ctrl,
	input  logic [ADDR_W-1:0] push_addr_a,
	input  logic [ADDR_W-1:0] push_addr_b,
	input  logic [WORD_W-1:0] push_value,
	output logic              full,
	input  logic              pop,
	output logic              empty,
	output ctrl_t             pop_ctrl,
	output logic [ADDR_W-1:0] pop_addr_a,
	output logic [ADDR_W-1:0] pop_addr_b,
	output logic [WORD_W-1:0] pop_value
);
	localparam int Q_DEPTH = WSTK_QUEUE_DEPTH;
	localparam int PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int CNT_W   = $clog2(Q_DEPTH + 1);

	ctrl_t             ctrl_q   [Q_DEPTH];
	logic [ADDR_W-1:0] addr_a_q [Q_DEPTH];
	logic [ADDR_W-1:0] addr_b_q [Q_DEPTH];
	logic [WORD_W-1:0] value_q  [Q_DEPTH];

	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (count_q == CNT_W'(Q_DEPTH));
	assign empty = (count_q == '0);

	assign pop_ctrl   = ctrl_q[rd_ptr_q];
	assign pop_addr_a = addr_a_q[rd_ptr_q];
	assign pop_addr_b = addr_b_q[rd_ptr_q];
	assign pop_value  = value_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			ctrl_q[wr_ptr_q]   <= push_ctrl;
			addr_a_q[wr_ptr_q] <= push_addr_a;
			addr_b_q[wr_ptr_q] <= push_addr_b;
			value_q[wr_ptr_q]  <= push_value;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end
endmodule

### hw/rtl/wstk_front.sv
// ----------------------------------------------------------------------------
// Word stack front end
// Accepts actions, checks them against the fill count and queues commands.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module wstk_front
	import wstk_pkg::*;
#(
	parameter int STACK_DEPTH = WSTK_STACK_DEPTH,
	parameter int SWAP_REACH  = WSTK_SWAP_REACH,
	parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	wstk_req_if.sink          req,
	input  logic              q_full,
	output logic              q_push,
	output ctrl_t             q_ctrl,
	output logic [ADDR_W-1:0] q_addr_a,
	output logic [ADDR_W-1:0] q_addr_b,
	output logic [WORD_W-1:0] q_value
);
	localparam int CNT_W = $clog2(STACK_DEPTH + 1);
	localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

	logic [CNT_W-1:0] count_q;
	logic [CNT_W-1:0] count_nxt;
	logic [CMP_W-1:0] pos_x;
	logic [CMP_W-1:0] cnt_x;
	logic [CMP_W-1:0] top_x;
	logic [CMP_W-1:0] other_x;
	op_t              op;
	status_t          status;

	assign req.ready = !q_full;
	assign q_push    = req.valid && !q_full;
	assign q_value   = {req.value_word3, req.value_word2, req.value_word1, req.value_word0};

	assign op      = op_t'(req.action);
	assign pos_x   = CMP_W'(req.position);
	assign cnt_x   = CMP_W'(count_q);
	assign top_x   = cnt_x - 1'b1;
	assign other_x = top_x - pos_x;

	always_comb begin
		count_nxt = count_q;
		status    = ST_OK;
		q_addr_a  = '0;
		q_addr_b  = '0;
		unique case (op)
			OP_PUSH: begin
				if (count_q < CNT_W'(STACK_DEPTH)) begin
					count_nxt = count_q + 1'b1;
					q_addr_a  = count_q[ADDR_W-1:0];
				end else begin
					status = ST_OVERFLOW;
				end
			end
			OP_POP: begin
				if (count_q != '0) begin
					count_nxt = count_q - 1'b1;
				end else begin
					status = ST_UNDERFLOW;
				end
			end
			OP_PEEK: begin
				if (pos_x < cnt_x) begin
					q_addr_a = ADDR_W'(other_x);
				end else begin
					status = ST_NOACCESS;
				end
			end
			OP_SWAP: begin
				if (pos_x != '0 && pos_x <= CMP_W'(SWAP_REACH) && pos_x < cnt_x) begin
					q_addr_a = ADDR_W'(top_x);
					q_addr_b = ADDR_W'(other_x);
				end else begin
					status = ST_NOACCESS;
				end
			end
			default: status = ST_NOACCESS;
		endcase
	end

	assign q_ctrl = '{op: op, status: status, fill: FILL_W'(count_nxt)};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (q_push) begin
			count_q <= count_nxt;
		end
	end
endmodule

### hw/rtl/wstk_back.sv
// ----------------------------------------------------------------------------
// Word stack back end
// Executes queued commands on the single-port entry memory, drives results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "word_stack_push_pop_peek_swap_top_macros.svh"

module wstk_back
	import wstk_pkg::*;
#(
	parameter int STACK_DEPTH = WSTK_STACK_DEPTH,
	parameter int ADDR_W      = $clog2(STACK_DEPTH)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              q_empty,
	output logic              q_pop,
	input  ctrl_t             q_ctrl,
	input  logic [ADDR_W-1:0] q_addr_a,
	input  logic [ADDR_W-1:0] q_addr_b,
	input  logic [WORD_W-1:0] q_value,
	wstk_rsp_if.source        rsp
);
	typedef enum logic [2:0] {
		S_IDLE,
		S_PEEK,
		S_SWAP_A,
		S_SWAP_B,
		S_SWAP_C
	} state_t;

	logic [WORD_W-1:0] mem [STACK_DEPTH];

	state_t            state_q;
	logic              out_valid_q;
	logic [WORD_W-1:0] out_word_q;
	status_t           out_status_q;
	logic [FILL_W-1:0] out_fill_q;
	logic [FILL_W-1:0] fill_q;
	logic [ADDR_W-1:0] addr_a_q;
	logic [ADDR_W-1:0] addr_b_q;
	logic [WORD_W-1:0] top_q;
	logic [WORD_W-1:0] rdata_q;

	logic              out_free;
	logic              out_load;
	logic              immediate;
	logic              mem_we;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_waddr;
	logic [ADDR_W-1:0] mem_raddr;
	logic [WORD_W-1:0] mem_wdata;

	assign out_free  = !out_valid_q || rsp.ready;
	assign q_pop     = (state_q == S_IDLE) && !q_empty && out_free;
	assign immediate = (q_ctrl.status != ST_OK) || (q_ctrl.op == OP_PUSH)
		|| (q_ctrl.op == OP_POP);
	assign out_load  = (q_pop && immediate) || (state_q == S_PEEK) || (state_q == S_SWAP_C);

	always_comb begin
		mem_we    = 1'b0;
		mem_re    = 1'b0;
		mem_waddr = addr_a_q;
		mem_raddr = q_addr_a;
		mem_wdata = rdata_q;
		unique case (state_q)
			S_IDLE: begin
				if (q_pop && q_ctrl.status == ST_OK) begin
					mem_we    = (q_ctrl.op == OP_PUSH);
					mem_waddr = q_addr_a;
					mem_wdata = q_value;
					mem_re    = (q_ctrl.op == OP_PEEK) || (q_ctrl.op == OP_SWAP);
				end
			end
			S_PEEK: ;
			S_SWAP_A: begin
				mem_re    = 1'b1;
				mem_raddr = addr_b_q;
			end
			S_SWAP_B: begin
				mem_we = 1'b1;
			end
			S_SWAP_C: begin
				mem_we    = 1'b1;
				mem_waddr = addr_b_q;
				mem_wdata = top_q;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (mem_re) begin
			rdata_q <= mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			out_valid_q  <= 1'b0;
			out_word_q   <= '0;
			out_status_q <= ST_OK;
			out_fill_q   <= '0;
			fill_q       <= '0;
			addr_a_q     <= '0;
			addr_b_q     <= '0;
			top_q        <= '0;
		end else begin
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_IDLE: begin
					if (q_pop) begin
						fill_q   <= q_ctrl.fill;
						addr_a_q <= q_addr_a;
						addr_b_q <= q_addr_b;
						if (immediate) begin
							out_word_q   <= '0;
							out_status_q <= q_ctrl.status;
							out_fill_q   <= q_ctrl.fill;
						end else if (q_ctrl.op == OP_PEEK) begin
							state_q <= S_PEEK;
						end else begin
							state_q <= S_SWAP_A;
						end
					end
				end
				S_PEEK: begin
					out_word_q   <= rdata_q;
					out_status_q <= ST_OK;
					out_fill_q   <= fill_q;
					state_q      <= S_IDLE;
				end
				S_SWAP_A: begin
					top_q   <= rdata_q;
					state_q <= S_SWAP_B;
				end
				S_SWAP_B: begin
					state_q <= S_SWAP_C;
				end
				S_SWAP_C: begin
					out_word_q   <= '0;
					out_status_q <= ST_OK;
					out_fill_q   <= fill_q;
					state_q      <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp.valid      = out_valid_q;
	assign rsp.read_word0 = out_word_q[PART_W-1:0];
	assign rsp.read_word1 = out_word_q[2*PART_W-1:PART_W];
	assign rsp.read_word2 = out_word_q[3*PART_W-1:2*PART_W];
	assign rsp.read_word3 = out_word_q[4*PART_W-1:3*PART_W];
	assign rsp.status     = out_status_q;
	assign rsp.fill       = out_fill_q;

	// a multi-cycle command starts only once the result slot is empty or taken
	`WSTK_ASSERT(a_busy_no_result, (state_q != S_IDLE) |-> !out_valid_q, "result held while busy")
	`WSTK_ASSERT(a_swap_order, (state_q == S_SWAP_A) |=> (state_q == S_SWAP_B), "swap out of step")
	`WSTK_ASSERT(a_swap_write, (state_q == S_SWAP_B) |-> (mem_we && !mem_re), "swap write lost")
	`WSTK_ASSERT_NEVER(a_peek_no_write, (state_q == S_PEEK) && mem_we, "write during peek")
endmodule

### hw/rtl/word_stack_push_pop_peek_swap_top.sv
// ----------------------------------------------------------------------------
// Word stack, push/pop/peek/swap
// Operand stack of STACK_DEPTH 256-bit words with a fill count. Each request
// transaction carries one action and gives exactly one response transaction
// with a status and the fill after the action. The front end takes one
// request per cycle while its two-entry command queue has room; the back end
// owns a single memory port (one read or one write per cycle, registered
// read) and handles push, pop and any failed action in its idle state, a peek
// through S_PEEK and a swap through S_SWAP_A to S_SWAP_C (read top, read
// partner, write, write). Each request passes the command queue and the
// registered result slot before its response appears. The entry memory is not
// cleared: entries are only read below the fill count, so no clearing pass follows reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_stack_push_pop_peek_swap_top
	import wstk_pkg::*;
#(
	parameter int STACK_DEPTH = WSTK_STACK_DEPTH,
	parameter int SWAP_REACH  = WSTK_SWAP_REACH
) (
	input  logic       clk,
	input  logic       arst_n,
	wstk_req_if.sink   req,
	wstk_rsp_if.source rsp
);
	localparam int ADDR_W = $clog2(STACK_DEPTH);

	logic              push;
	logic              full;
	ctrl_t             push_ctrl;
	logic [ADDR_W-1:0] push_addr_a;
	logic [ADDR_W-1:0] push_addr_b;
	logic [WORD_W-1:0] push_value;

	logic              pop;
	logic              empty;
	ctrl_t             pop_ctrl;
	logic [ADDR_W-1:0] pop_addr_a;
	logic [ADDR_W-1:0] pop_addr_b;
	logic [WORD_W-1:0] pop_value;

	wstk_front #(
		.STACK_DEPTH (STACK_DEPTH),
		.SWAP_REACH  (SWAP_REACH),
		.ADDR_W      (ADDR_W)
	) u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.q_full   (full),
		.q_push   (push),
		.q_ctrl   (push_ctrl),
		.q_addr_a (push_addr_a),
		.q_addr_b (push_addr_b),
		.q_value  (push_value)
	);

	wstk_queue #(
		.ADDR_W (ADDR_W)
	) u_queue (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.push_ctrl   (push_ctrl),
		.push_addr_a (push_addr_a),
		.push_addr_b (push_addr_b),
		.push_value  (push_value),
		.full        (full),
		.pop         (pop),
		.empty       (empty),
		.pop_ctrl    (pop_ctrl),
		.pop_addr_a  (pop_addr_a),
		.pop_addr_b  (pop_addr_b),
		.pop_value   (pop_value)
	);

	wstk_back #(
		.STACK_DEPTH (STACK_DEPTH),
		.ADDR_W      (ADDR_W)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_empty  (empty),
		.q_pop    (pop),
		.q_ctrl   (pop_ctrl),
		.q_addr_a (pop_addr_a),
		.q_addr_b (pop_addr_b),
		.q_value  (pop_value),
		.rsp      (rsp)
	);
endmodule

### tb/word_stack_push_pop_peek_swap_top_test.sv
// ----------------------------------------------------------------------------
// Word stack push/pop/peek/swap testbench
// Drives stack actions over the request channel and predicts every response
// with a shadow stack of 256-bit words. A short directed table covers the
// empty, single-entry and reach limits. Random traffic follows, with one long
// receiver hold-off. Sender gaps and receiver stalls vary by phase.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module word_stack_push_pop_peek_swap_top_test;
	import wstk_pkg::*;

	localparam int WATCHDOG_LIMIT = 4000;
	localparam int MAX_REPORTS    = 10;

	typedef struct {
		op_t               op;
		logic [POS_W-1:0]  pos;
		logic [WORD_W-1:0] value;
		bit                typed;
		status_t           st;
		logic [FILL_W-1:0] fill;
		logic [WORD_W-1:0] rd;
	} stim_row_t;

	typedef struct packed {
		logic [WORD_W-1:0] rd;
		status_t           st;
		logic [FILL_W-1:0] fill;
	} stack_result_t;

	logic clk;
	logic arst_n;

	wstk_req_if req_ch ();
	wstk_rsp_if rsp_ch ();

	word_stack_push_pop_peek_swap_top i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	logic [WORD_W-1:0] stack_words [WSTK_STACK_DEPTH];
	int                stack_fill;
	stack_result_t     result_q [$];
	stim_row_t         directed_rows [$];

	int send_idle_pct;
	int stall_pct;
	int hold_len;
	int mismatches;
	int unexpected;
	int idle_cycles;
	int op_seen [4];
	int status_seen [4];
	int deepest;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic stack_result_t apply_action(op_t op, logic [POS_W-1:0] pos,
			logic [WORD_W-1:0] value);
		stack_result_t     r;
		logic [WORD_W-1:0] t;
		int                p;
		p    = int'(pos);
		r.rd = '0;
		r.st = ST_OK;
		case (op)
			OP_PUSH: begin
				if (stack_fill >= WSTK_STACK_DEPTH) begin
					r.st = ST_OVERFLOW;
				end else begin
					stack_words[stack_fill] = value;
					stack_fill++;
				end
			end
			OP_POP: begin
				if (stack_fill == 0) begin
					r.st = ST_UNDERFLOW;
				end else begin
					stack_fill--;
				end
			end
			OP_PEEK: begin
				if (p >= stack_fill) begin
					r.st = ST_NOACCESS;
				end else begin
					r.rd = stack_words[stack_fill - 1 - p];
				end
			end
			default: begin
				if (p == 0 || p > WSTK_SWAP_REACH || p >= stack_fill) begin
					r.st = ST_NOACCESS;
				end else begin
					t = stack_words[stack_fill - 1];
					stack_words[stack_fill - 1] = stack_words[stack_fill - 1 - p];
					stack_words[stack_fill - 1 - p] = t;
				end
			end
		endcase
		r.fill = stack_fill[FILL_W-1:0];
		return r;
	endfunction

	function automatic stim_row_t action_row(op_t op, int pos, logic [WORD_W-1:0] value,
			bit typed, status_t st, int fill, logic [WORD_W-1:0] rd);
		stim_row_t r;
		r.op    = op;
		r.pos   = pos[POS_W-1:0];
		r.value = value;
		r.typed = typed;
		r.st    = st;
		r.fill  = fill[FILL_W-1:0];
		r.rd    = rd;
		return r;
	endfunction

	function automatic logic [WORD_W-1:0] random_word();
		int                sel;
		logic [WORD_W-1:0] w;
		sel = $urandom_range(99);
		if (sel < 8) begin
			w = '1;
		end else if (sel < 16) begin
			w = '0;
		end else begin
			for (int i = 0; i < WORD_W / 32; i++)
				w[i*32 +: 32] = $urandom;
		end
		return w;
	endfunction

	function automatic stim_row_t random_action(int push_pct, int pop_pct, int peek_pct);
		int  sel;
		int  pos;
		int  lim;
		op_t op;
		sel = $urandom_range(99);
		if (sel < push_pct)
			op = OP_PUSH;
		else if (sel < push_pct + pop_pct)
			op = OP_POP;
		else if (sel < push_pct + pop_pct + peek_pct)
			op = OP_PEEK;
		else
			op = OP_SWAP;
		sel = $urandom_range(99);
		pos = $urandom_range(0, 1023);
		if (op == OP_PEEK) begin
			lim = (stack_fill + 2 > 1023) ? 1023 : stack_fill + 2;
			if (sel < 70 && stack_fill > 0)
				pos = $urandom_range(0, stack_fill - 1);
			else if (sel < 85)
				pos = $urandom_range(0, lim);
		end else if (op == OP_SWAP) begin
			lim = (stack_fill - 1 > WSTK_SWAP_REACH) ? WSTK_SWAP_REACH : stack_fill - 1;
			if (sel < 70 && stack_fill > 1)
				pos = $urandom_range(1, lim);
			else if (sel < 90)
				pos = $urandom_range(0, WSTK_SWAP_REACH + 2);
		end
		return action_row(op, pos, random_word(), 1'b0, ST_OK, 0, '0);
	endfunction

	function automatic stim_row_t mixed_action();
		if (stack_fill > 48)
			return random_action(25, 40, 20);
		return random_action(38, 24, 20);
	endfunction

	task automatic issue_action(stim_row_t r);
		stack_result_t pred;
		while ($urandom_range(99) < send_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.action      <= r.op;
		req_ch.position    <= r.pos;
		req_ch.value_word0 <= r.value[63:0];
		req_ch.value_word1 <= r.value[127:64];
		req_ch.value_word2 <= r.value[191:128];
		req_ch.value_word3 <= r.value[255:192];
		do
			@(posedge clk);
		while (!req_ch.ready);
		pred = apply_action(r.op, r.pos, r.value);
		if (r.typed)
			pred = '{rd: r.rd, st: r.st, fill: r.fill};
		result_q.push_back(pred);
		op_seen[r.op]++;
		if (stack_fill > deepest)
			deepest = stack_fill;
	endtask

	task automatic drain_results();
		while (result_q.size() != 0)
			@(posedge clk);
	endtask

	// response check
	always @(posedge clk) begin
		stack_result_t exp_r;
		stack_result_t got_r;
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got_r = '{rd: {rsp_ch.read_word3, rsp_ch.read_word2, rsp_ch.read_word1,
				rsp_ch.read_word0}, st: status_t'(rsp_ch.status), fill: rsp_ch.fill};
			status_seen[rsp_ch.status]++;
			if (result_q.size() == 0) begin
				unexpected++;
				if (mismatches + unexpected <= MAX_REPORTS)
					$display("unexpected transaction: status %0d fill %0d",
						rsp_ch.status, rsp_ch.fill);
			end else begin
				exp_r = result_q.pop_front();
				if (got_r.rd[63:0] !== exp_r.rd[63:0] ||
						got_r.rd[127:64] !== exp_r.rd[127:64] ||
						got_r.rd[191:128] !== exp_r.rd[191:128] ||
						got_r.rd[255:192] !== exp_r.rd[255:192] ||
						got_r.st !== exp_r.st || got_r.fill !== exp_r.fill) begin
					mismatches++;
					if (mismatches + unexpected <= MAX_REPORTS) begin
						$display("mismatch: expected status %0d fill %0d word %h",
							exp_r.st, exp_r.fill, exp_r.rd);
						$display("          actual   status %0d fill %0d word %h",
							got_r.st, got_r.fill, got_r.rd);
					end
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
			idle_cycles = 0;
		end else begin
			idle_cycles++;
			if (idle_cycles >= WATCHDOG_LIMIT) begin
				$display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
				$display("word_stack_push_pop_peek_swap_top_test: errors");
				$finish;
			end
		end
	end

	// response side: random stalls, or one long hold-off on request
	initial begin
		int k;
		rsp_ch.ready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_len > 0) begin
				rsp_ch.ready <= 1'b0;
				for (k = 0; k < hold_len; k++)
					@(posedge clk);
				hold_len = 0;
			end else begin
				rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
			end
		end
	end

	initial begin
		logic [WORD_W-1:0] pattern;
		arst_n             = 1'b0;
		req_ch.valid       = 1'b0;
		req_ch.action      = OP_PUSH;
		req_ch.position    = '0;
		req_ch.value_word0 = '0;
		req_ch.value_word1 = '0;
		req_ch.value_word2 = '0;
		req_ch.value_word3 = '0;
		stack_fill    = 0;
		send_idle_pct = 0;
		stall_pct     = 0;
		hold_len      = 0;
		mismatches    = 0;
		unexpected    = 0;
		idle_cycles   = 0;
		deepest       = 0;
		for (int i = 0; i < 4; i++) begin
			op_seen[i]     = 0;
			status_seen[i] = 0;
		end

		directed_rows.push_back(action_row(OP_POP,  0,    '0, 1, ST_UNDERFLOW, 0, '0));
		directed_rows.push_back(action_row(OP_PEEK, 0,    '0, 1, ST_NOACCESS,  0, '0));
		directed_rows.push_back(action_row(OP_PUSH, 1023, '1, 1, ST_OK,        1, '0));
		directed_rows.push_back(action_row(OP_PEEK, 0,    '0, 1, ST_OK,        1, '1));
		directed_rows.push_back(action_row(OP_PUSH, 0,    '0, 1, ST_OK,        2, '0));
		directed_rows.push_back(action_row(OP_SWAP, 0,    '0, 1, ST_NOACCESS,  2, '0));
		directed_rows.push_back(action_row(OP_SWAP, 1,    '0, 1, ST_OK,        2, '0));
		directed_rows.push_back(action_row(OP_PEEK, 0,    '0, 1, ST_OK,        2, '1));
		directed_rows.push_back(action_row(OP_PEEK, 1,    '0, 1, ST_OK,        2, '0));
		directed_rows.push_back(action_row(OP_PEEK, 1023, '0, 1, ST_NOACCESS,  2, '0));
		directed_rows.push_back(action_row(OP_PEEK, 2,    '0, 1, ST_NOACCESS,  2, '0));
		for (int k = 0; k < 14; k++) begin
			pattern = {64'hA5A5_0000_0000_0000 | 64'(k), 64'h5A5A_0000_0000_0000 | 64'(k),
				~64'(k), 64'(k) << 32};
			directed_rows.push_back(action_row(OP_PUSH, k, pattern, 0, ST_OK, 0, '0));
		end
		directed_rows.push_back(action_row(OP_SWAP, WSTK_SWAP_REACH, '0, 0, ST_OK, 0, '0));
		directed_rows.push_back(action_row(OP_PEEK, WSTK_SWAP_REACH, '0, 0, ST_OK, 0, '0));
		directed_rows.push_back(action_row(OP_SWAP, WSTK_SWAP_REACH + 1, '0, 1,
			ST_NOACCESS, 16, '0));

		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[i])
			issue_action(directed_rows[i]);
		req_ch.valid <= 1'b0;
		drain_results();

		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin send_idle_pct = 0;  stall_pct = 0;  end
				1: begin send_idle_pct = 52; stall_pct = 0;  end
				2: begin send_idle_pct = 0;  stall_pct = 52; end
				default: begin send_idle_pct = 32; stall_pct = 32; end
			endcase
			if (ph == 0) begin
				// long receiver hold-off so the request side backs up
				hold_len = 80;
				repeat (30) issue_action(mixed_action());
			end
			repeat (220) issue_action(mixed_action());
			req_ch.valid <= 1'b0;
			drain_results();
		end

		repeat (12) @(posedge clk);
		$display("covered push %0d, pop %0d, peek %0d, swap %0d; deepest fill %0d",
			op_seen[OP_PUSH], op_seen[OP_POP], op_seen[OP_PEEK], op_seen[OP_SWAP], deepest);
		$display("status ok %0d, overflow %0d, underflow %0d, no access %0d; %0d bad",
			status_seen[ST_OK], status_seen[ST_OVERFLOW], status_seen[ST_UNDERFLOW],
			status_seen[ST_NOACCESS], mismatches + unexpected);
		if (mismatches == 0 && unexpected == 0 && result_q.size() == 0) begin
			$display("word_stack_push_pop_peek_swap_top_test: clean");
		end else begin
			$display("word_stack_push_pop_peek_swap_top_test: errors");
		end
		$finish;
	end

endmodule

### filelist.f
+incdir+hw/rtl
hw/rtl/wstk_pkg.sv
hw/rtl/wstk_req_if.sv
hw/rtl/wstk_rsp_if.sv
hw/rtl/wstk_queue.sv
hw/rtl/wstk_front.sv
hw/rtl/wstk_back.sv
hw/rtl/word_stack_push_pop_peek_swap_top.sv
tb/word_stack_push_pop_peek_swap_top_test.sv
